FILE: hdl/ecd_pkg.sv
package ecd_pkg;

    localparam int unsigned Latency = 10;

    // floor(x / 675) = (x * DayRecip) >> DayShift, exact for x < 2**25
    localparam logic [25:0] DayRecip   = 26'd50903317;
    localparam int unsigned DayShift   = 35;
    localparam logic [9:0]  DayDivisor = 10'd675;

    // floor(x / 3600) for x < 2**17
    localparam logic [17:0] HourRecip = 18'd149131;
    localparam int unsigned HourShift = 29;
    localparam logic [11:0] SecsPerHour = 12'd3600;

    // floor(x / 60) for x < 2**12
    localparam logic [12:0] MinRecip = 13'd4370;
    localparam int unsigned MinShift = 18;
    localparam logic [5:0]  SecsPerMin = 6'd60;

    // floor(x / 1461) for x < 2**16
    localparam logic [16:0] CycRecip = 17'd91868;
    localparam int unsigned CycShift = 27;
    localparam logic [10:0] DaysPerCycle = 11'd1461;

    // Day numbers counted from 1968-03-01
    localparam logic [15:0] EpochOffset = 16'd671;
    // First epoch day on or after 2100-03-01, where the 4-year rule breaks
    localparam logic [15:0] CenturySkip = 16'd47541;
    localparam logic [11:0] BaseYear    = 12'd1968;

    localparam logic [8:0] DaysPerYear = 9'd365;

    // First day of each month in a March-based year
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/epoch_seconds_to_civil_date_unit.sv
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 (no leap seconds) into the
// Gregorian date and time of day, with the full leap-year rule; every input maps to a date
// between 1970 and 2106. A transaction is taken whenever start is high: busy is always low,
// so one timestamp can enter on every clock. The result is on the ports for one cycle,
// flagged by o_valid; the receiver cannot stall it, and results leave in the order their
// timestamps arrived. The pipeline has ten register stages: constant-divisor multiplies
// by reciprocal, each followed by a register, then the back-multiply and subtract, the
// year and month split.
module epoch_seconds_to_civil_date_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [31:0] i_epoch_seconds,
    output logic        busy,
    output logic        o_valid,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);
    import ecd_pkg::*;

    logic [Latency-1:0] r_vld;

    // stage 1
    logic [50:0] r_dprod;
    logic [24:0] r1_x;
    logic [6:0]  r1_lo;
    // stage 2
    logic [15:0] r2_days;
    logic [25:0] r2_qm;
    logic [24:0] r2_x;
    logic [6:0]  r2_lo;
    // stage 3
    logic [16:0] r3_rem;
    logic [15:0] r3_z;
    // stage 4
    logic [34:0] r4_hprod;
    logic [32:0] r4_cprod;
    logic [16:0] r4_rem;
    logic [15:0] r4_z;
    // stage 5
    logic [4:0]  r5_hour;
    logic [5:0]  r5_cyc;
    logic [16:0] r5_hm;
    logic [15:0] r5_cm;
    logic [16:0] r5_rem;
    logic [15:0] r5_z;
    // stage 6
    logic [4:0]  r6_hour;
    logic [5:0]  r6_cyc;
    logic [11:0] r6_rem2;
    logic [10:0] r6_r;
    // stage 7
    logic [4:0]  r7_hour;
    logic [5:0]  r7_cyc;
    logic [11:0] r7_rem2;
    logic [10:0] r7_r;
    logic [24:0] r7_mprod;
    logic [1:0]  r7_yoc;
    // stage 8
    logic [4:0]  r8_hour;
    logic [5:0]  r8_minute;
    logic [11:0] r8_mm;
    logic [11:0] r8_rem2;
    logic [8:0]  r8_doy;
    logic [11:0] r8_yb;
    // stage 9
    logic [4:0]  r9_hour;
    logic [5:0]  r9_minute;
    logic [5:0]  r9_second;
    logic [8:0]  r9_doy;
    logic [3:0]  r9_mp;
    logic [11:0] r9_yb;
    // stage 10 (output)
    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [5:0]  r_second;

    logic [24:0] n_diff;
    logic [15:0] n_z;
    logic [16:0] n_rem2;
    logic [15:0] n_r;
    logic [1:0]  n_yoc;
    logic [5:0]  n_minute;
    logic [8:0]  n_doy;
    logic [11:0] n_sec;
    logic [3:0]  n_mp;
    logic [8:0]  n_day;
    logic [3:0]  n_month;
    logic [11:0] n_year;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[Latency-2:0], start};
        end
    end

    always_comb begin
        n_diff = r2_x - r2_qm[24:0];
        if (r2_days >= CenturySkip) begin
            n_z = r2_days + EpochOffset + 16'd1;
        end else begin
            n_z = r2_days + EpochOffset;
        end

        n_rem2 = r5_rem - r5_hm;
        n_r    = r5_z - r5_cm;

        if (r6_r >= 11'd1095) begin
            n_yoc = 2'd3;
        end else if (r6_r >= 11'd730) begin
            n_yoc = 2'd2;
        end else if (r6_r >= 11'd365) begin
            n_yoc = 2'd1;
        end else begin
            n_yoc = 2'd0;
        end

        n_minute = r7_mprod[MinShift+5:MinShift];
        n_doy    = 9'(r7_r - 11'(r7_yoc) * 11'(DaysPerYear));

        n_sec = r8_rem2 - r8_mm;
        n_mp  = '0;
        for (int k = 1; k < 12; k++) begin
            if (r8_doy >= month_start(4'(k))) begin
                n_mp = n_mp + 4'd1;
            end
        end

        n_day = r9_doy - month_start(r9_mp) + 9'd1;
        if (r9_mp < 4'd10) begin
            n_month = r9_mp + 4'd3;
            n_year  = r9_yb;
        end else begin
            n_month = r9_mp - 4'd9;
            n_year  = r9_yb + 12'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dprod <= 51'(i_epoch_seconds[31:7]) * 51'(DayRecip);
        r1_x    <= i_epoch_seconds[31:7];
        r1_lo   <= i_epoch_seconds[6:0];

        r2_days <= r_dprod[DayShift+15:DayShift];
        r2_qm   <= 26'(r_dprod[DayShift+15:DayShift]) * 26'(DayDivisor);
        r2_x    <= r1_x;
        r2_lo   <= r1_lo;

        r3_rem <= {n_diff[9:0], r2_lo};
        r3_z   <= n_z;

        r4_hprod <= 35'(r3_rem) * 35'(HourRecip);
        r4_cprod <= 33'(r3_z) * 33'(CycRecip);
        r4_rem   <= r3_rem;
        r4_z     <= r3_z;

        r5_hour <= r4_hprod[HourShift+4:HourShift];
        r5_cyc  <= r4_cprod[CycShift+5:CycShift];
        r5_hm   <= 17'(r4_hprod[HourShift+4:HourShift]) * 17'(SecsPerHour);
        r5_cm   <= 16'(r4_cprod[CycShift+5:CycShift]) * 16'(DaysPerCycle);
        r5_rem  <= r4_rem;
        r5_z    <= r4_z;

        r6_hour <= r5_hour;
        r6_cyc  <= r5_cyc;
        r6_rem2 <= n_rem2[11:0];
        r6_r    <= n_r[10:0];

        r7_hour  <= r6_hour;
        r7_cyc   <= r6_cyc;
        r7_rem2  <= r6_rem2;
        r7_r     <= r6_r;
        r7_mprod <= 25'(r6_rem2) * 25'(MinRecip);
        r7_yoc   <= n_yoc;

        r8_hour   <= r7_hour;
        r8_minute <= n_minute;
        r8_mm     <= 12'(n_minute) * 12'(SecsPerMin);
        r8_rem2   <= r7_rem2;
        r8_doy    <= n_doy;
        r8_yb     <= BaseYear + 12'({r7_cyc, r7_yoc});

        r9_hour   <= r8_hour;
        r9_minute <= r8_minute;
        r9_second <= n_sec[5:0];
        r9_doy    <= r8_doy;
        r9_mp     <= n_mp;
        r9_yb     <= r8_yb;

        r_year   <= n_year;
        r_month  <= n_month;
        r_day    <= n_day[4:0];
        r_hour   <= r9_hour;
        r_minute <= r9_minute;
        r_second <= r9_second;
    end

    assign busy     = 1'b0;
    assign o_valid  = r_vld[Latency-1];
    assign o_year   = r_year;
    assign o_month  = r_month;
    assign o_day    = r_day;
    assign o_hour   = r_hour;
    assign o_minute = r_minute;
    assign o_second = r_second;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##10 o_valid)
        else $error("transaction lost in pipeline");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 10))
        else $error("result without a transaction");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month >= 4'd1 && o_month <= 4'd12 && o_day >= 5'd1 && o_day <= 5'd31))
        else $error("month or day out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour < 5'd24 && o_minute < 6'd60 && o_second < 6'd60))
        else $error("time of day out of range");

    a_february: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_month == 4'd2) |-> (o_day <= 5'd29))
        else $error("february day out of range");
`endif

endmodule

FILE: sim/date_checker.sv
module date_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] i_epoch_seconds,
    input  logic        i_valid,
    input  logic [11:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [5:0]  i_second,
    output int unsigned o_n_failures,
    output int unsigned o_n_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SecsPerDay  = 86400;
    localparam int unsigned SecsPerHour = 3600;
    localparam int unsigned SecsPerMin  = 60;
    localparam int unsigned FirstYear   = 1970;
    localparam int unsigned MonthDays[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_civil;

    typedef struct {
        logic [31:0] secs;
        t_civil      date;
    } t_stamp;

    t_stamp date_queue[$];

    function automatic bit is_leap(input int unsigned y);
        if (y % 4 != 0) return 1'b0;
        if (y % 100 != 0) return 1'b1;
        return (y % 400) == 0;
    endfunction

    function automatic t_civil civil_date_of(input logic [31:0] secs);
        int unsigned days;
        int unsigned rem;
        int unsigned yr;
        int unsigned mon;
        int unsigned len;
        t_civil      d;
        days = secs / SecsPerDay;
        rem  = secs % SecsPerDay;
        yr   = FirstYear;
        len  = is_leap(yr) ? 366 : 365;
        while (days >= len) begin
            days -= len;
            yr++;
            len = is_leap(yr) ? 366 : 365;
        end
        mon = 1;
        while (mon < 12) begin
            len = MonthDays[mon - 1] + ((mon == 2 && is_leap(yr)) ? 1 : 0);
            if (days < len) break;
            days -= len;
            mon++;
        end
        d.year   = 12'(yr);
        d.month  = 4'(mon);
        d.day    = 5'(days + 1);
        d.hour   = 5'(rem / SecsPerHour);
        d.minute = 6'((rem % SecsPerHour) / SecsPerMin);
        d.second = 6'(rem % SecsPerMin);
        return d;
    endfunction

    always @(posedge i_clk) begin : watch
        t_stamp want;
        t_civil got;
        if (i_rst_n) begin
            if (start && !busy) begin
                want.secs = i_epoch_seconds;
                want.date = civil_date_of(i_epoch_seconds);
                date_queue.push_back(want);
            end
            if (i_valid) begin
                got = '{i_year, i_month, i_day, i_hour, i_minute, i_second};
                if (date_queue.size() == 0) begin
                    o_n_failures++;
                    if (o_n_failures <= 10)
                        $display("%0t: unexpected transaction %0d-%0d-%0d %0d:%0d:%0d",
                                 $realtime, got.year, got.month, got.day,
                                 got.hour, got.minute, got.second);
                end else begin
                    want = date_queue.pop_front();
                    if (want.date.year !== got.year || want.date.month !== got.month ||
                        want.date.day !== got.day || want.date.hour !== got.hour ||
                        want.date.minute !== got.minute || want.date.second !== got.second) begin
                        o_n_failures++;
                        if (o_n_failures <= 10)
                            $display({"%0t: mismatch for %0d s: expected %0d-%0d-%0d ",
                                      "%0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d"},
                                     $realtime, want.secs,
                                     want.date.year, want.date.month, want.date.day,
                                     want.date.hour, want.date.minute, want.date.second,
                                     got.year, got.month, got.day,
                                     got.hour, got.minute, got.second);
                    end
                end
            end
        end
        o_n_waiting <= date_queue.size();
    end

endmodule

FILE: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NumRandom = 1100;

    // 2100-02-28 00:00:00, in 2100, the first non-leap century year after 1970
    localparam logic [31:0] NoLeapCentury = 32'd4107456000;

    localparam logic [31:0] CornerSecs[22] = '{
        32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
        32'd31535999, 32'd68169600, 32'd94694399, 32'd94694400,
        32'd951782400, 32'd951868799, 32'd951868800,
        32'd4107542399, 32'd4107542400, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h5555_5555, 32'hFFFF_FFFE, 32'hFFFF_FFFF
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] i_epoch_seconds = '0;
    logic        busy;
    logic        o_valid;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;
    int unsigned n_fail;
    int unsigned n_waiting;

    always #6 i_clk = ~i_clk;

    epoch_seconds_to_civil_date_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_epoch_seconds(i_epoch_seconds),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day          (o_day),
        .o_hour         (o_hour),
        .o_minute       (o_minute),
        .o_second       (o_second)
    );

    date_checker watch_dates (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_epoch_seconds(i_epoch_seconds),
        .i_valid        (o_valid),
        .i_year         (o_year),
        .i_month        (o_month),
        .i_day          (o_day),
        .i_hour         (o_hour),
        .i_minute       (o_minute),
        .i_second       (o_second),
        .o_n_failures   (n_fail),
        .o_n_waiting    (n_waiting)
    );

    // holds start high until the transaction is taken
    task automatic send_stamp(input logic [31:0] secs);
        start           <= 1'b1;
        i_epoch_seconds <= secs;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // day edges, random stamps, the far end of the range and the 2100 non-leap year
    function automatic logic [31:0] random_stamp();
        logic [31:0] day_num;
        logic [31:0] r;
        day_num = $urandom_range(0, 49709);
        case ($urandom_range(0, 4))
            0: r = $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: r = day_num * 86400;
                    1: r = day_num * 86400 + 1;
                    2: r = day_num * 86400 + 86398;
                    default: r = day_num * 86400 + 86399;
                endcase
            end
            2: r = day_num * 86400 + $urandom_range(0, 86399);
            3: r = 32'hFFFF_FFFF - $urandom_range(0, 200_000_000);
            default: r = NoLeapCentury + $urandom_range(0, 3 * 86400);
        endcase
        return r;
    endfunction

    initial begin
        #2_000_000;
        $display("** epoch_seconds_to_civil_date_unit: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (CornerSecs[i]) send_stamp(CornerSecs[i]);
        sent = 0;
        while (sent < NumRandom) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            for (int k = 0; k < burst && sent < NumRandom; k++) begin
                send_stamp(random_stamp());
                sent++;
            end
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start <= 1'b0;
        @(negedge i_clk);
        while (n_waiting != 0) @(negedge i_clk);
        repeat (ecd_pkg::Latency + 4) @(posedge i_clk);
        @(negedge i_clk);
        if (n_fail == 0 && n_waiting == 0) begin
            $display("** epoch_seconds_to_civil_date_unit: PASSED **");
        end else begin
            $display("** epoch_seconds_to_civil_date_unit: FAILED **");
        end
        $finish;
    end

endmodule
